@@ rtl/eqr_pkg.sv @@
`timescale 1ns / 1ps

package eqr_pkg;

   typedef logic signed [71:0] wide_type;

   localparam int unsigned Q30_SHIFT = 30;
   localparam wide_type HALF_Q30 = 72'sd1 <<< (Q30_SHIFT - 1);
   localparam logic [30:0] ONE_Q30 = 31'd1 << Q30_SHIFT;

   localparam logic [63:0] DEG_TO_RAD = 64'd19190098069;

   localparam int unsigned DIV360_SHIFT = 26;
   localparam logic [17:0] DIV360_RECIP = 18'(((64'd1 << 26) + 64'd359) / 64'd360);

   localparam int unsigned SIN_SHIFT [8] = '{0, 33, 35, 36, 37, 37, 38, 38};
   localparam int unsigned COS_SHIFT [8] = '{0, 31, 34, 35, 36, 37, 38, 38};

   localparam logic [30:0] SIN_RECIP [8] = '{
      31'd1,
      31'(((64'd1 << 33) + 64'd5) / 64'd6),
      31'(((64'd1 << 35) + 64'd19) / 64'd20),
      31'(((64'd1 << 36) + 64'd41) / 64'd42),
      31'(((64'd1 << 37) + 64'd71) / 64'd72),
      31'(((64'd1 << 37) + 64'd109) / 64'd110),
      31'(((64'd1 << 38) + 64'd155) / 64'd156),
      31'(((64'd1 << 38) + 64'd209) / 64'd210)
   };

   localparam logic [30:0] COS_RECIP [8] = '{
      31'd1,
      31'(((64'd1 << 31) + 64'd1) / 64'd2),
      31'(((64'd1 << 34) + 64'd11) / 64'd12),
      31'(((64'd1 << 35) + 64'd29) / 64'd30),
      31'(((64'd1 << 36) + 64'd55) / 64'd56),
      31'(((64'd1 << 37) + 64'd89) / 64'd90),
      31'(((64'd1 << 38) + 64'd131) / 64'd132),
      31'(((64'd1 << 38) + 64'd181) / 64'd182)
   };

   // Drops 30 fraction bits, rounding to nearest with ties away from zero.
   function automatic wide_type round_q30(input wide_type v);
      wide_type r;
      if (v < 0) begin
         r = -((-v + HALF_Q30) >>> Q30_SHIFT);
      end else begin
         r = (v + HALF_Q30) >>> Q30_SHIFT;
      end
      return r;
   endfunction

endpackage

@@ rtl/eqr_sincos.sv @@
`timescale 1ns / 1ps

module eqr_sincos #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [31:0] sine,
   output logic signed [31:0] cosine
);

   typedef struct packed {
      logic neg;
      logic cneg;
      logic swap;
   } flag_type;

   localparam int K = ANGLE_FRAC_BITS + 1;
   localparam int UNIT = 1 << K;
   localparam int PER = 360 * UNIT;
   localparam int OFF = ((32768 + PER - 1) / PER) * PER;
   localparam int U_W = $clog2(32768 + OFF);
   localparam int Q_W = $clog2((32768 + OFF) / PER + 1);
   localparam int A_W = $clog2(180 * UNIT + 1);
   localparam int A3_W = $clog2(45 * UNIT + 1);

   logic [U_W-1:0]  u_ff;
   logic [Q_W-1:0]  q_ff;
   logic [A_W-1:0]  a_ff;
   logic            neg_ff;
   logic [A3_W-1:0] a3_ff;
   logic [29:0]     x_ff;
   logic [29:0]     xs_ff;
   flag_type        flg_ff [0:16];
   logic [29:0]     x2_ff [0:12];

   logic signed [U_W:0] u_sum;
   logic [U_W-1:0]      u_in;
   logic [63:0]         q_prod;
   logic [Q_W-1:0]      q_in;
   logic signed [U_W:0] m0;
   logic signed [U_W:0] m1;
   logic [A_W-1:0]      a_in;
   logic [A_W-1:0]      a2;
   flag_type            flg_in;
   logic [A3_W-1:0]     a3_in;
   logic [29:0]         x_in;
   logic [29:0]         x2_in;

   always_comb begin
      u_sum = (U_W + 1)'($signed(angle)) + (U_W + 1)'(OFF);
      u_in = u_sum[U_W-1:0];
      q_prod = 64'(u_in >> K) * 64'(eqr_pkg::DIV360_RECIP);
      q_in = Q_W'(q_prod >> eqr_pkg::DIV360_SHIFT);
   end

   always_comb begin
      m0 = $signed({1'b0, u_ff}) - $signed((U_W + 1)'(int'(q_ff) * PER));
      m1 = (m0 > (U_W + 1)'(180 * UNIT)) ? m0 - (U_W + 1)'(PER) : m0;
      a_in = A_W'((m1 < 0) ? -m1 : m1);
   end

   always_comb begin
      a2 = a_ff;
      flg_in.neg = neg_ff;
      flg_in.cneg = 1'b0;
      flg_in.swap = 1'b0;
      if (a2 > A_W'(90 * UNIT)) begin
         a2 = A_W'(180 * UNIT) - a2;
         flg_in.cneg = 1'b1;
      end
      if (a2 > A_W'(45 * UNIT)) begin
         a2 = A_W'(90 * UNIT) - a2;
         flg_in.swap = 1'b1;
      end
      a3_in = A3_W'(a2);
   end

   always_comb begin
      x_in = 30'((64'(a3_ff) * eqr_pkg::DEG_TO_RAD + (64'd1 << (ANGLE_FRAC_BITS + 10)))
                 >> (ANGLE_FRAC_BITS + 11));
      x2_in = 30'((64'(x_ff) * 64'(x_ff) + (64'd1 << 29)) >> 30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
         q_ff <= q_in;
         a_ff <= a_in;
         neg_ff <= m1 < 0;
         a3_ff <= a3_in;
         flg_ff[0] <= flg_in;
         x_ff <= x_in;
         xs_ff <= x_ff;
         x2_ff[0] <= x2_in;
         for (int k = 1; k <= 16; k++) begin
            flg_ff[k] <= flg_ff[k-1];
         end
         for (int k = 1; k <= 12; k++) begin
            x2_ff[k] <= x2_ff[k-1];
         end
      end
   end

   logic [30:0]        term_s [0:7];
   logic [30:0]        term_c [0:7];
   logic signed [31:0] as_acc_ff [1:7];
   logic signed [31:0] ac_acc_ff [1:7];
   logic [30:0]        as_r_ff [1:7];
   logic [30:0]        ac_r_ff [1:7];
   logic signed [31:0] bs_acc_ff [1:7];
   logic signed [31:0] bc_acc_ff [1:7];
   logic [61:0]        bs_q_ff [1:7];
   logic [61:0]        bc_q_ff [1:7];
   logic signed [31:0] prev_s [1:7];
   logic signed [31:0] prev_c [1:7];

   assign term_s[0] = 31'(xs_ff);
   assign term_c[0] = eqr_pkg::ONE_Q30;

   for (genvar j = 1; j <= 7; j++) begin : g_step
      logic signed [31:0] as_acc_in;
      logic signed [31:0] ac_acc_in;

      assign term_s[j] = 31'(bs_q_ff[j] >> eqr_pkg::SIN_SHIFT[j]);
      assign term_c[j] = 31'(bc_q_ff[j] >> eqr_pkg::COS_SHIFT[j]);

      if (j == 1) begin : g_first
         assign prev_s[j] = '0;
         assign prev_c[j] = '0;
      end else begin : g_rest
         assign prev_s[j] = bs_acc_ff[j-1];
         assign prev_c[j] = bc_acc_ff[j-1];
      end

      if (j % 2 == 0) begin : g_sub
         assign as_acc_in = prev_s[j] - $signed(32'(term_s[j-1]));
         assign ac_acc_in = prev_c[j] - $signed(32'(term_c[j-1]));
      end else begin : g_add
         assign as_acc_in = prev_s[j] + $signed(32'(term_s[j-1]));
         assign ac_acc_in = prev_c[j] + $signed(32'(term_c[j-1]));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            as_acc_ff[j] <= as_acc_in;
            ac_acc_ff[j] <= ac_acc_in;
            as_r_ff[j] <= 31'((64'(term_s[j-1]) * 64'(x2_ff[2*j-2]) + (64'd1 << 29)) >> 30);
            ac_r_ff[j] <= 31'((64'(term_c[j-1]) * 64'(x2_ff[2*j-2]) + (64'd1 << 29)) >> 30);
            bs_acc_ff[j] <= as_acc_ff[j];
            bc_acc_ff[j] <= ac_acc_ff[j];
            bs_q_ff[j] <= 62'(64'(as_r_ff[j]) * 64'(eqr_pkg::SIN_RECIP[j]));
            bc_q_ff[j] <= 62'(64'(ac_r_ff[j]) * 64'(eqr_pkg::COS_RECIP[j]));
         end
      end
   end

   logic signed [31:0] s_fin;
   logic signed [31:0] c_fin;
   logic signed [31:0] sine_in;
   logic signed [31:0] cosine_in;
   logic signed [31:0] sine_ff;
   logic signed [31:0] cosine_ff;

   always_comb begin
      s_fin = bs_acc_ff[7] - $signed(32'(term_s[7]));
      c_fin = bc_acc_ff[7] - $signed(32'(term_c[7]));
      sine_in = flg_ff[16].swap ? c_fin : s_fin;
      cosine_in = flg_ff[16].swap ? s_fin : c_fin;
      if (flg_ff[16].neg) begin
         sine_in = -sine_in;
      end
      if (flg_ff[16].cneg) begin
         cosine_in = -cosine_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign sine = sine_ff;
   assign cosine = cosine_ff;

endmodule

@@ rtl/euler_to_quaternion_rotate_top.sv @@
`timescale 1ns / 1ps

// Converts roll, pitch and yaw angles into a unit quaternion (ZYX order) and,
// when req_tuser is set, rotates the supplied base quaternion by it.
// The request channel carries one word per orientation sample; the response
// channel returns one word with the four Q1.14 components, rounded to
// nearest and saturated to plus or minus one.
// The block is a single pipeline of 25 register stages, through which every
// accepted word passes to rsp_tvalid. A new word is accepted in every cycle
// while the output is not stalled, so the throughput is one word per cycle.
// The depth is mostly set by the seven term steps of the sine and cosine
// series, each a multiply stage followed by a reciprocal multiply stage.
// When the receiver holds rsp_tready low with a word waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; no word is lost
// or repeated, and bubbles inside the pipeline stay where they are.
// Synchronous reset clears every valid bit and leaves the data registers
// as they are; the block can take a word in the first cycle after reset.
module euler_to_quaternion_rotate_top #(
   parameter int QUAT_FRAC_BITS = 14,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // roll_angle, pitch_angle, yaw_angle, base_w, base_x, base_y, base_z
   input  logic [111:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // quat_w, quat_x, quat_y, quat_z
   output logic [63:0]  rsp_tdata
);

   localparam int DEPTH = 25;
   localparam int SIDE_DEPTH = 23;
   localparam int B_W = (QUAT_FRAC_BITS + 2 > 16) ? QUAT_FRAC_BITS + 2 : 16;
   localparam eqr_pkg::wide_type LIM = 72'sd1 <<< QUAT_FRAC_BITS;
   localparam int LIM16 = 1 << QUAT_FRAC_BITS;

   localparam int E_IDX [4][4] = '{'{0, 1, 2, 3}, '{1, 0, 3, 2}, '{2, 3, 0, 1}, '{3, 2, 1, 0}};
   localparam logic SUB [4][4] = '{'{1'b0, 1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1},
                                   '{1'b0, 1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b0}};

   typedef struct packed {
      logic        kind;
      logic [15:0] bw;
      logic [15:0] bx;
      logic [15:0] by;
      logic [15:0] bz;
   } side_type;

   logic               en;
   logic [DEPTH-1:0]   v_ff;
   side_type           side_ff [0:SIDE_DEPTH-1];
   logic signed [31:0] sr, cr, sp, cp, sy, cy;

   assign en = !v_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = v_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= {req_tuser, req_tdata[63:48], req_tdata[79:64], req_tdata[95:80],
                        req_tdata[111:96]};
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   eqr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock(clock), .en(en), .angle(req_tdata[15:0]), .sine(sr), .cosine(cr));
   eqr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .en(en), .angle(req_tdata[31:16]), .sine(sp), .cosine(cp));
   eqr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
      .clock(clock), .en(en), .angle(req_tdata[47:32]), .sine(sy), .cosine(cy));

   logic signed [31:0] cc_ff, ss_ff, sc_ff, cs_ff, cy_ff, sy_ff;
   logic signed [63:0] t_ff [0:7];
   logic signed [31:0] e_ff [0:3];

   function automatic logic signed [31:0] pair(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return 32'(eqr_pkg::round_q30(eqr_pkg::wide_type'(a) * eqr_pkg::wide_type'(b)));
   endfunction

   function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return 64'(eqr_pkg::wide_type'(a) * eqr_pkg::wide_type'(b));
   endfunction

   function automatic logic signed [31:0] sum30(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic sub);
      eqr_pkg::wide_type s;
      s = sub ? eqr_pkg::wide_type'(a) - eqr_pkg::wide_type'(b)
              : eqr_pkg::wide_type'(a) + eqr_pkg::wide_type'(b);
      return 32'(eqr_pkg::round_q30(s));
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff <= pair(cr, cp);
         ss_ff <= pair(sr, sp);
         sc_ff <= pair(sr, cp);
         cs_ff <= pair(cr, sp);
         cy_ff <= cy;
         sy_ff <= sy;
         t_ff[0] <= mul64(cc_ff, cy_ff);
         t_ff[1] <= mul64(ss_ff, sy_ff);
         t_ff[2] <= mul64(sc_ff, cy_ff);
         t_ff[3] <= mul64(cs_ff, sy_ff);
         t_ff[4] <= mul64(cs_ff, cy_ff);
         t_ff[5] <= mul64(sc_ff, sy_ff);
         t_ff[6] <= mul64(cc_ff, sy_ff);
         t_ff[7] <= mul64(ss_ff, cy_ff);
         e_ff[0] <= sum30(t_ff[0], t_ff[1], 1'b0);
         e_ff[1] <= sum30(t_ff[2], t_ff[3], 1'b1);
         e_ff[2] <= sum30(t_ff[4], t_ff[5], 1'b0);
         e_ff[3] <= sum30(t_ff[6], t_ff[7], 1'b1);
      end
   end

   logic signed [B_W-1:0]    bq [0:3];
   logic signed [B_W+31:0]   pr_in [0:3][0:3];
   logic signed [B_W+31:0]   pr_ff [0:3][0:3];
   logic [63:0]              out_in;
   logic [63:0]              out_ff;
   side_type                 sd;

   always_comb begin
      sd = side_ff[SIDE_DEPTH-1];
      if (sd.kind) begin
         bq[0] = B_W'($signed(sd.bw));
         bq[1] = B_W'($signed(sd.bx));
         bq[2] = B_W'($signed(sd.by));
         bq[3] = B_W'($signed(sd.bz));
      end else begin
         bq[0] = B_W'(LIM);
         bq[1] = '0;
         bq[2] = '0;
         bq[3] = '0;
      end
      for (int c = 0; c < 4; c++) begin
         for (int t = 0; t < 4; t++) begin
            pr_in[c][t] = (B_W + 32)'(eqr_pkg::wide_type'(bq[t])
                                       * eqr_pkg::wide_type'(e_ff[E_IDX[c][t]]));
         end
      end
   end

   always_comb begin
      eqr_pkg::wide_type acc;
      eqr_pkg::wide_type v;
      out_in = '0;
      for (int c = 0; c < 4; c++) begin
         acc = '0;
         for (int t = 0; t < 4; t++) begin
            if (SUB[c][t]) begin
               acc = acc - eqr_pkg::wide_type'(pr_ff[c][t]);
            end else begin
               acc = acc + eqr_pkg::wide_type'(pr_ff[c][t]);
            end
         end
         v = eqr_pkg::round_q30(acc);
         if (v > LIM) begin
            v = LIM;
         end
         if (v < -LIM) begin
            v = -LIM;
         end
         out_in[16*c +: 16] = v[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= pr_in;
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (QUAT_FRAC_BITS > 14)
         || ($signed(rsp_tdata[15:0]) <= LIM16 && $signed(rsp_tdata[15:0]) >= -LIM16
             && $signed(rsp_tdata[63:48]) <= LIM16 && $signed(rsp_tdata[63:48]) >= -LIM16))
      else $error("Result component outside the saturation range.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(v_ff) && $stable(out_ff))
      else $error("Pipeline moved while the output word was stalled.");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && v_ff == '0)
      else $error("Valid bits survived reset.");

endmodule

@@ tb/euler_to_quaternion_rotate_top_tb.sv @@
`timescale 1ns / 1ps

module euler_to_quaternion_rotate_top_tb;

   localparam int ITEM_COUNT = 1350;
   localparam int STALL_LIMIT = 3000;
   localparam int PRESSURE_AT = 1150;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam longint Q_ONE = 64'sd1 <<< 14;

   typedef struct {
      logic                has_quat;
      logic                kind;
      logic signed [15:0]  roll;
      logic signed [15:0]  pitch;
      logic signed [15:0]  yaw;
      logic signed [15:0]  bw;
      logic signed [15:0]  bx;
      logic signed [15:0]  by;
      logic signed [15:0]  bz;
      logic signed [15:0]  qw;
      logic signed [15:0]  qx;
      logic signed [15:0]  qy;
      logic signed [15:0]  qz;
   } orient_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;

   orient_row_type directed_rows [$];
   logic [63:0]  pending_quats [$];
   int           words_sent = 0;
   int           words_issued = 0;
   int           words_checked = 0;
   int           rotate_words = 0;
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   bit           stimulus_done = 1'b0;
   bit           pressure_active = 1'b0;

   euler_to_quaternion_rotate_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic longint round_bits(input longint v, input int s);
      longint half_lsb;
      half_lsb = 64'sd1 <<< (s - 1);
      if (v >= 0) begin
         return (v + half_lsb) >>> s;
      end
      return -((-v + half_lsb) >>> s);
   endfunction

   function automatic void half_angle_sincos(input logic [15:0] raw, output longint sn,
                                             output longint cs);
      longint m, a, x, x2, ts, tc, s, c, tmp;
      bit neg, cneg, swap;
      m = longint'($signed(raw)) % 92160;
      cneg = 1'b0;
      swap = 1'b0;
      if (m < 0) m += 92160;
      if (m > 46080) m -= 92160;
      neg = m < 0;
      a = neg ? -m : m;
      if (a > 23040) begin
         a = 46080 - a;
         cneg = 1'b1;
      end
      if (a > 11520) begin
         a = 23040 - a;
         swap = 1'b1;
      end
      x = (a * 64'sd19190098069 + (64'sd1 <<< 17)) >>> 18;
      x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
      ts = x;
      s = x;
      tc = 64'sd1 <<< 30;
      c = tc;
      for (int i = 1; i <= 7; i++) begin
         ts = ((ts * x2 + (64'sd1 <<< 29)) >>> 30) / ((2 * i) * (2 * i + 1));
         tc = ((tc * x2 + (64'sd1 <<< 29)) >>> 30) / ((2 * i - 1) * (2 * i));
         if (i % 2 == 1) begin
            s -= ts;
            c -= tc;
         end else begin
            s += ts;
            c += tc;
         end
      end
      if (swap) begin
         tmp = s;
         s = c;
         c = tmp;
      end
      sn = neg ? -s : s;
      cs = cneg ? -c : c;
   endfunction

   function automatic longint triple(input longint a, input longint b, input longint c);
      return round_bits(a * b, 30) * c;
   endfunction

   function automatic logic [15:0] clamp_q14(input longint acc);
      longint v;
      v = round_bits(acc, 30);
      if (v > Q_ONE) v = Q_ONE;
      if (v < -Q_ONE) v = -Q_ONE;
      return v[15:0];
   endfunction

   function automatic logic [63:0] rotated_quat(input logic kind, input logic [111:0] d);
      longint sr, cr, sp, cp, sy, cy, ew, ex, ey, ez, bw, bx, by, bz;
      half_angle_sincos(d[15:0], sr, cr);
      half_angle_sincos(d[31:16], sp, cp);
      half_angle_sincos(d[47:32], sy, cy);
      ew = round_bits(triple(cr, cp, cy) + triple(sr, sp, sy), 30);
      ex = round_bits(triple(sr, cp, cy) - triple(cr, sp, sy), 30);
      ey = round_bits(triple(cr, sp, cy) + triple(sr, cp, sy), 30);
      ez = round_bits(triple(cr, cp, sy) - triple(sr, sp, cy), 30);
      if (kind) begin
         bw = $signed(d[63:48]);
         bx = $signed(d[79:64]);
         by = $signed(d[95:80]);
         bz = $signed(d[111:96]);
      end else begin
         bw = Q_ONE;
         bx = 0;
         by = 0;
         bz = 0;
      end
      return {clamp_q14(bw * ez + bx * ey - by * ex + bz * ew),
              clamp_q14(bw * ey - bx * ez + by * ew + bz * ex),
              clamp_q14(bw * ex + bx * ew + by * ez - bz * ey),
              clamp_q14(bw * ew - bx * ex - by * ey - bz * ez)};
   endfunction

   function automatic orient_row_type row(input int kind, input int r, input int p,
                                          input int y, input int w, input int bx,
                                          input int by, input int bz);
      orient_row_type t;
      t = '{has_quat: 1'b0, kind: 1'(kind), roll: 16'(r), pitch: 16'(p), yaw: 16'(y),
            bw: 16'(w), bx: 16'(bx), by: 16'(by), bz: 16'(bz),
            qw: '0, qx: '0, qy: '0, qz: '0};
      return t;
   endfunction

   function automatic orient_row_type known(input orient_row_type t, input int w, input int x,
                                            input int y, input int z);
      t.has_quat = 1'b1;
      t.qw = 16'(w);
      t.qx = 16'(x);
      t.qy = 16'(y);
      t.qz = 16'(z);
      return t;
   endfunction

   function automatic logic signed [15:0] random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 16'($urandom_range(0, 46080) - 23040);
      if (pick < 7) return 16'($urandom);
      return 16'($urandom_range(0, 16) * 2880 - 23040 + $urandom_range(0, 6) - 3);
   endfunction

   function automatic logic signed [15:0] random_base();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return 16'($urandom_range(0, 32768) - 16384);
      if (pick < 9) return 16'($urandom);
      return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
   endfunction

   initial begin
      directed_rows.push_back(known(row(0, 0, 0, 0, 0, 0, 0, 0), 16384, 0, 0, 0));
      directed_rows.push_back(known(row(0, 23040, 0, 0, 0, 0, 0, 0), 0, 16384, 0, 0));
      directed_rows.push_back(known(row(0, -23040, 0, 0, 0, 0, 0, 0), 0, -16384, 0, 0));
      directed_rows.push_back(known(row(0, 0, 23040, 0, 0, 0, 0, 0), 0, 0, 16384, 0));
      directed_rows.push_back(known(row(0, 0, 0, 23040, 0, 0, 0, 0), 0, 0, 0, 16384));
      directed_rows.push_back(known(row(1, 0, 0, 0, -32768, -32768, -32768, -32768),
                                    -16384, -16384, -16384, -16384));
      directed_rows.push_back(known(row(1, 0, 0, 0, 32767, 32767, 32767, 32767),
                                    16384, 16384, 16384, 16384));
      directed_rows.push_back(known(row(0, 0, 0, 0, 32767, -32768, 123, -5),
                                    16384, 0, 0, 0));
      directed_rows.push_back(known(row(1, 0, 0, 0, 0, 16384, 0, 0), 0, 16384, 0, 0));
      directed_rows.push_back(row(0, 32767, -32768, 32767, 0, 0, 0, 0));
      directed_rows.push_back(row(0, -32768, 32767, -32768, 0, 0, 0, 0));
      directed_rows.push_back(row(0, 5760, 5760, 5760, 0, 0, 0, 0));
      directed_rows.push_back(row(0, 11520, -11520, 11521, 0, 0, 0, 0));
      directed_rows.push_back(row(0, 11519, 17280, -17280, 0, 0, 0, 0));
      directed_rows.push_back(row(0, 1, -1, 2, 0, 0, 0, 0));
      directed_rows.push_back(row(1, 3000, -7000, 12000, 11585, 0, 11585, 0));
      directed_rows.push_back(row(1, -23040, 23040, -23040, -16384, 16384, -16384, 16384));
      directed_rows.push_back(row(1, 7777, 7777, 7777, -32768, 32767, -32768, 32767));
      directed_rows.push_back(row(1, -32768, 32767, 100, 8192, -8192, 8192, -8192));
   end

   always @(posedge clock) begin
      logic [63:0] want;
      logic [15:0] got_f, want_f;
      string names [4];
      names = '{"quat_w", "quat_x", "quat_y", "quat_z"};
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_quats.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_quats.pop_front();
               for (int f = 0; f < 4; f++) begin
                  want_f = want[16*f +: 16];
                  got_f = rsp_tdata[16*f +: 16];
                  if (got_f !== want_f) begin
                     $error("%s: expected %0d, got %0d", names[f], $signed(want_f),
                            $signed(got_f));
                     error_count++;
                  end
               end
               words_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (words_sent < directed_rows.size() && directed_rows[words_sent].has_quat) begin
               pending_quats.push_back({directed_rows[words_sent].qz,
                                        directed_rows[words_sent].qy,
                                        directed_rows[words_sent].qx,
                                        directed_rows[words_sent].qw});
            end else begin
               pending_quats.push_back(rotated_quat(req_tuser, req_tdata));
            end
            if (req_tuser) rotate_words++;
            words_sent++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("euler_to_quaternion_rotate_top_tb: done, errors");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      orient_row_type t;
      int n;
      if (!reset && req_tvalid && req_tready) begin
         words_issued++;
      end
      n = words_issued;
      if (n < 300) begin
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
      end else if (n < 600) begin
         sender_idle_pct = 55;
         receiver_stall_pct = 0;
      end else if (n < 900) begin
         sender_idle_pct = 0;
         receiver_stall_pct = 55;
      end else if (n < 1100) begin
         sender_idle_pct = 22;
         receiver_stall_pct = 22;
      end else begin
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
      end
      if (!reset && (!req_tvalid || req_tready)) begin
         if (n >= ITEM_COUNT) begin
            req_tvalid <= 1'b0;
            stimulus_done <= 1'b1;
         end else if ($urandom_range(0, 99) < sender_idle_pct) begin
            req_tvalid <= 1'b0;
         end else begin
            if (n < directed_rows.size()) begin
               t = directed_rows[n];
            end else begin
               t = row($urandom_range(0, 2) != 0, random_angle(), random_angle(),
                       random_angle(), random_base(), random_base(), random_base(),
                       random_base());
            end
            req_tuser <= t.kind;
            req_tdata <= {t.bz, t.by, t.bx, t.bw, t.yaw, t.pitch, t.roll};
            req_tvalid <= 1'b1;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_active && words_sent >= PRESSURE_AT && words_sent < PRESSURE_AT + 5) begin
            pressure_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   initial begin
      wait (stimulus_done);
      wait (pending_quats.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words (%0d rotating a base), checked %0d responses.",
               words_sent, rotate_words, words_checked);
      $display("Idle phases on each side plus one long receiver hold were exercised.");
      if (error_count == 0 && pending_quats.size() == 0) begin
         $display("euler_to_quaternion_rotate_top_tb: done, clean");
      end else begin
         $display("euler_to_quaternion_rotate_top_tb: done, errors");
      end
      $finish;
   end

endmodule
